// File: sv/psrl_pkg.sv
// Package for the per-source rate limiter: table entry layout, controller
// command and status bundles, state codes and register indexes. No dependencies.
package psrl_pkg;

    localparam logic [7:0]  COUNT_MAX          = 8'd255;
    localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd5;
    localparam logic [15:0] WINDOW_SECONDS_RST = 16'd60;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  count;
        logic [31:0] win_origin;
    } t_entry;

    typedef struct packed {
        logic start;     // latch the request, restart the scan
        logic scan;      // issue the next table read, check the previous one
        logic capture;   // compute the entry update and the verdict
        logic write;     // write the entry back, advance the pointer on a miss
        logic load_out;  // move the verdict into the output register
    } t_ctl_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_busy;
    } t_ctl_stat;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// File: sv/psrl_ctrl.sv
// Controller of the per-source rate limiter: sequences accept, scan, write-back
// and result hand-off. Depends on psrl_pkg.
module psrl_ctrl
    import psrl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output t_ctl_cmd  o_cmd,
    input  t_ctl_stat i_stat
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.miss) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: sv/psrl_datapath.sv
// Datapath of the per-source rate limiter: config registers, entry memory,
// scan counters, update arithmetic and output register. Depends on psrl_pkg.
module psrl_datapath
    import psrl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [31:0]            i_source_address,
    input  logic [31:0]            i_now_seconds,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_blocked,
    input  t_ctl_cmd               i_cmd,
    output t_ctl_stat              o_stat
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [7:0]  r_max_attempts;
    logic [15:0] r_window_seconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_attempts   <= MAX_ATTEMPTS_RST;
            r_window_seconds <= WINDOW_SECONDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_ATTEMPTS:   r_max_attempts   <= i_cfg_data[7:0];
                REG_WINDOW_SECONDS: r_window_seconds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request latch
    logic [31:0] r_address;
    logic [31:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_address <= i_source_address;
            r_now     <= i_now_seconds;
        end
    end

    // Entries are filled in pointer order, so index < pointer is valid until
    // the pointer first wraps; after that every entry is valid.
    logic [IW-1:0] r_ptr;
    logic          r_full;
    logic [CW-1:0] limit;

    assign limit = r_full ? CW'(TABLE_ENTRIES) : CW'(r_ptr);

    // entry memory
    t_entry        r_mem [TABLE_ENTRIES];
    t_entry        r_mem_q;
    t_entry        r_wr_entry;
    logic [IW-1:0] r_wr_idx;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_chk_idx;
    logic          r_chk_vld;
    logic          r_is_miss;
    logic          r_res_blocked;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && (r_rd_idx < limit)) begin
            r_mem_q <= r_mem[r_rd_idx[IW-1:0]];
        end
        if (i_cmd.write) begin
            r_mem[r_wr_idx] <= r_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_chk_idx <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_rd_idx < limit) begin
                r_chk_idx <= r_rd_idx;
                r_chk_vld <= 1'b1;
                r_rd_idx  <= r_rd_idx + CW'(1);
            end else begin
                r_chk_vld <= 1'b0;
            end
        end
    end

    logic match;
    logic last;

    assign match = r_chk_vld && (r_mem_q.address == r_address);
    assign last  = r_chk_vld && (r_chk_idx == limit - CW'(1));

    assign o_stat.hit      = i_cmd.scan && match;
    assign o_stat.miss     = i_cmd.scan && !match && ((limit == '0) || last);
    assign o_stat.out_busy = o_out_valid && !i_out_ready;

    // update arithmetic
    logic [31:0] elapsed;
    logic        expired;
    logic [7:0]  count_inc;

    assign elapsed   = r_now - r_mem_q.win_origin;
    assign expired   = elapsed > {16'd0, r_window_seconds};
    assign count_inc = (r_mem_q.count == COUNT_MAX) ? COUNT_MAX : r_mem_q.count + 8'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wr_entry.address <= r_address;
            r_is_miss          <= !match;
            if (!match) begin
                r_wr_idx              <= r_ptr;
                r_wr_entry.count      <= 8'd1;
                r_wr_entry.win_origin <= r_now;
                r_res_blocked         <= 1'b0;
            end else if (expired) begin
                r_wr_idx              <= r_chk_idx[IW-1:0];
                r_wr_entry.count      <= 8'd1;
                r_wr_entry.win_origin <= r_now;
                r_res_blocked         <= 1'b0;
            end else begin
                r_wr_idx              <= r_chk_idx[IW-1:0];
                r_wr_entry.count      <= count_inc;
                r_wr_entry.win_origin <= r_mem_q.win_origin;
                r_res_blocked         <= count_inc > r_max_attempts;
            end
        end
    end

    // replacement pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.write && r_is_miss) begin
            if (r_ptr == IW'(TABLE_ENTRIES - 1)) begin
                r_ptr  <= '0;
                r_full <= 1'b1;
            end else begin
                r_ptr <= r_ptr + IW'(1);
            end
        end
    end

    // output register
    logic r_out_vld;
    logic r_out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_blocked <= r_res_blocked;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_blocked   = r_out_blocked;

endmodule

// File: sv/per_source_rate_limiter.sv
// Top level of the per-source rate limiter: joins the controller and the
// datapath. Depends on psrl_pkg, psrl_ctrl and psrl_datapath.
//
//  channel   direction  beat contents
//  s_axis    in         tdata[31:0] source_address, tdata[63:32] now_seconds
//  m_axis    out        tdata[0] blocked, tdata[7:1] zero
//  i_cfg_*   in         index 0 max_attempts, index 1 window_seconds
//
// One request is handled at a time. The time from accept to the result beat
// grows with the index of the entry that holds its source, and a miss scans
// every valid entry. This is set by the entry memory's single read port,
// scanned one entry per cycle.
// Reset clears the fill pointer, so the table starts empty; no clearing pass.
// A stalled result sits in the output register; a new request is still
// accepted, and only its own hand-off waits for that register to drain.
module per_source_rate_limiter
    import psrl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [63:0]            s_axis_tdata,  // [31:0] source_address, [63:32] now_seconds
    // verdict stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata   // [0] blocked, [7:1] zero
);

    t_ctl_cmd  cmd;
    t_ctl_stat stat;
    logic      blocked;

    // sequence each request: accept, scan, write back, hand off
    psrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // table, counters and verdict arithmetic
    psrl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_source_address (s_axis_tdata[31:0]),
        .i_now_seconds    (s_axis_tdata[63:32]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_blocked        (blocked),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );

    // pad the single verdict bit to a whole byte
    assign m_axis_tdata = {7'd0, blocked};

endmodule

// File: sv/psrl_checker.sv
// Port-level checks for the per-source rate limiter, bound to the top level.
// Depends on per_source_rate_limiter.
module psrl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // one request in flight: no beat is taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // a verdict never appears the cycle after its request is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result raised too early after accept");

    // stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("result padding not zero");

endmodule

bind per_source_rate_limiter psrl_checker u_psrl_checker (.*);
